// File: rtl/core/cet_pkg.sv
`timescale 1ns / 1ps
package cet_pkg;

    localparam int unsigned SYMBOLS_DEFAULT = 1024;
    localparam logic [15:0] BAND_GAP_RESET = 16'd256;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] ADDR_BAND_GAP = 2'd0;

    typedef enum logic [2:0] {
        FN_ACTIVATE  = 3'd0,
        FN_ADD_ONE   = 3'd1,
        FN_ADD_ALL   = 3'd2,
        FN_ELEM      = 3'd3,
        FN_PARTIAL   = 3'd4,
        FN_FREEZE    = 3'd5,
        FN_CLEAR     = 3'd6
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SINGLE_RD,
        ST_SINGLE_WAIT,
        ST_DIV,
        ST_SINGLE_WR,
        ST_SCAN1,
        ST_SCAN2,
        ST_OUT
    } state_t;

    // clip a 50-bit signed sum to the excitation range
    function automatic logic [31:0] clip_exc(input logic signed [49:0] v);
        logic [31:0] r;
        if (v < 0) r = '0;
        else if (v > 50'sh0_FFFF_FFFF) r = 32'hFFFF_FFFF;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic [15:0] clip_cnt(input logic signed [33:0] v);
        logic [15:0] r;
        if (v < 0) r = '0;
        else if (v > 34'sd65535) r = 16'hFFFF;
        else r = v[15:0];
        return r;
    endfunction

endpackage

// File: rtl/core/cet_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit a cycle while busy, 32-bit quotient
module cet_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [15:0] den,
    output logic        busy,
    output logic [31:0] quo
);
    logic [31:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [5:0]  n_reg, n_next;
    logic [15:0] d_reg;
    logic [16:0] sh;

    assign busy = (n_reg != 6'd0);
    assign quo  = q_reg;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        sh = {r_reg[15:0], q_reg[31]};
        if (start) begin
            q_next = num;
            r_next = '0;
            n_next = 6'd32;
        end else if (busy) begin
            if (sh >= {1'b0, d_reg}) begin
                r_next = sh - {1'b0, d_reg};
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = sh;
                q_next = {q_reg[30:0], 1'b0};
            end
            n_next = n_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= '0;
        end else begin
            n_reg <= n_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) d_reg <= den;
    end
endmodule

// File: rtl/core/confabulation_excitation_table.sv
`timescale 1ns / 1ps
// Confabulation excitation table.
// Input channel s_*: one word per command (func, symbol_index, value, k,
// multi_mode); result channel m_*: one word per command. Band gap is set
// through the APB port (register 0 at address 0); the user must write it
// only while the block is idle; the block itself does not enforce it.
// State sits in one 49-bit wide memory of SYMBOLS rows (excitation, count,
// mark), one read and one write port, with a registered read port.
// An error, an unused code or an index outside the table goes straight to
// the result; activate reads the row and writes it back; add-to-symbol also
// waits for the serial divider for links (not started with a zero band gap).
// Whole-table commands read one row per cycle behind the registered read,
// with a first pass that finds a maximum before the main pass for negative
// k, or for partial in multi mode. One command is in work at a time;
// s_ready is high only when idle and no result waits.
// After reset a clearing pass zeroes every row of the memory; no word is
// taken during it. Clear-and-unfreeze also runs that pass.
// A result waits in m_* registers, unchanged, until taken; the next word is
// accepted only after the result leaves.
module confabulation_excitation_table #(
    parameter int unsigned SYMBOLS = cet_pkg::SYMBOLS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [9:0]  s_symbol_index,
    input  logic signed [31:0] s_value,
    input  logic signed [16:0] s_k,
    input  logic        s_multi_mode,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_winner_found,
    output logic [9:0]  m_winner_index,
    output logic [10:0] m_kept_count,
    output logic        m_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [cet_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int unsigned RW = 49;

    // row: {mark, count[15:0], exc[31:0]}
    logic [RW-1:0] mem [SYMBOLS];
    logic [RW-1:0] rd_data;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [RW-1:0] wr_data;
    logic          wr_en;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    // config
    logic [15:0] band_gap_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == cet_pkg::ADDR_BAND_GAP) ? {16'd0, band_gap_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_gap_reg <= cet_pkg::BAND_GAP_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == cet_pkg::ADDR_BAND_GAP) begin
            band_gap_reg <= pwdata[15:0];
        end
    end

    cet_pkg::state_t state_reg, state_next;
    logic [2:0]  func_reg;
    logic [9:0]  idx_reg;
    logic signed [31:0] val_reg;
    logic signed [16:0] k_reg;
    logic        multi_reg;
    logic        frozen_reg, frozen_next;
    logic [AW:0] rp_reg, rp_next;     // read pointer
    logic [AW:0] wp_reg, wp_next;     // row being processed (read data)
    logic        rv_reg, rv_next;     // rd_data valid for wp
    logic [15:0] mxc_reg, mxc_next;
    logic [31:0] mxe_reg, mxe_next;
    logic        any_reg, any_next;
    logic [31:0] best_exc_reg, best_exc_next;
    logic [AW-1:0] best_reg, best_next;
    logic        have_reg, have_next;
    logic [10:0] kept_reg, kept_next;
    logic        err_reg, err_next;
    logic signed [17:0] kact_reg, kact_next;
    logic [31:0] thr_reg, thr_next;
    logic [31:0] s_reg, s_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        mark_reg, mark_next;
    logic        mv_reg, mv_next;
    logic        pass2_reg, pass2_next;
    logic        dstart;
    logic        dbusy;
    logic [31:0] dquo;
    logic        func_reg_fix;        // empty multi-mode partial runs as freeze

    cet_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart),
        .num(s_reg), .den(band_gap_reg), .busy(dbusy), .quo(dquo)
    );

    assign s_ready = (state_reg == cet_pkg::ST_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_winner_found = have_reg;
    assign m_winner_index = have_reg ? 10'(best_reg) : 10'd0;
    assign m_kept_count = kept_reg;
    assign m_error = err_reg;

    // row fields
    logic [31:0] r_exc;
    logic [15:0] r_cnt;
    logic        r_mark;
    assign r_exc  = rd_data[31:0];
    assign r_cnt  = rd_data[47:32];
    assign r_mark = rd_data[48];

    logic signed [33:0] inc;          // k * band_gap
    logic signed [49:0] sum_add;
    logic signed [33:0] cnt_sum;
    logic               sel_all;
    logic               qual;
    logic               is_elem;
    logic               need_max;
    logic [AW-1:0]      wrow;
    logic [31:0]        act_exc;

    assign inc = 34'(k_reg) * $signed({18'd0, band_gap_reg});
    assign act_exc = cet_pkg::clip_exc(50'(inc));
    assign sum_add = 50'(signed'({1'b0, r_exc})) + 50'(inc);
    assign cnt_sum = 34'(signed'({1'b0, r_cnt})) + 34'(k_reg);
    assign sel_all = frozen_reg ? r_mark : (r_exc != 32'd0);
    assign qual = (r_exc != 32'd0) && (18'(signed'({1'b0, r_cnt})) >= kact_reg);
    assign is_elem = (func_reg == cet_pkg::FN_ELEM);
    assign need_max = (is_elem || func_reg == cet_pkg::FN_PARTIAL)
                      && (multi_reg && !is_elem || k_reg < 0);
    assign wrow = wp_reg[AW-1:0];

    always_comb begin
        state_next = state_reg;
        frozen_next = frozen_reg;
        rp_next = rp_reg; wp_next = wp_reg; rv_next = 1'b0;
        mxc_next = mxc_reg; mxe_next = mxe_reg; any_next = any_reg;
        best_exc_next = best_exc_reg; best_next = best_reg; have_next = have_reg;
        kept_next = kept_reg; err_next = err_reg; kact_next = kact_reg;
        thr_next = thr_reg; s_next = s_reg; cnt_next = cnt_reg; mark_next = mark_reg;
        mv_next = mv_reg; pass2_next = pass2_reg;
        rd_addr = rp_reg[AW-1:0];
        wr_en = 1'b0; wr_addr = wrow; wr_data = rd_data;
        dstart = 1'b0;
        func_reg_fix = 1'b0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (state_reg)
            cet_pkg::ST_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = rp_reg[AW-1:0];
                wr_data = '0;
                rp_next = rp_reg + 1'b1;
                if (rp_reg == (AW+1)'(SYMBOLS - 1)) begin
                    frozen_next = 1'b0;
                    state_next = (func_reg == cet_pkg::FN_CLEAR) ?
                                 cet_pkg::ST_OUT : cet_pkg::ST_IDLE;
                end
            end
            cet_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    have_next = 1'b0; kept_next = '0; err_next = 1'b0;
                    rp_next = '0; wp_next = '0;
                    mxc_next = '0; mxe_next = '0; any_next = 1'b0;
                    best_exc_next = '0; best_next = '0; pass2_next = 1'b0;
                    kact_next = 18'(s_k);
                    case (s_func)
                        cet_pkg::FN_ACTIVATE, cet_pkg::FN_ADD_ONE:
                            state_next = (32'(s_symbol_index) < SYMBOLS) ?
                                         cet_pkg::ST_SINGLE_RD : cet_pkg::ST_OUT;
                        cet_pkg::FN_ADD_ALL, cet_pkg::FN_ELEM,
                        cet_pkg::FN_PARTIAL, cet_pkg::FN_FREEZE:
                            state_next = cet_pkg::ST_SCAN1;
                        cet_pkg::FN_CLEAR: state_next = cet_pkg::ST_CLEAR;
                        default: state_next = cet_pkg::ST_OUT;
                    endcase
                    if (s_func == cet_pkg::FN_ACTIVATE && s_k < 0) begin
                        err_next = 1'b1;
                        state_next = cet_pkg::ST_OUT;
                    end
                end
            end
            cet_pkg::ST_SINGLE_RD: begin
                rd_addr = AW'(idx_reg);
                state_next = cet_pkg::ST_SINGLE_WAIT;
            end
            cet_pkg::ST_SINGLE_WAIT: begin
                mark_next = r_mark;
                if (frozen_reg && !r_mark) begin
                    state_next = cet_pkg::ST_OUT;
                end else if (func_reg == cet_pkg::FN_ACTIVATE) begin
                    s_next = act_exc;
                    cnt_next = (k_reg > 17'sd65535) ? 16'hFFFF : k_reg[15:0];
                    state_next = cet_pkg::ST_SINGLE_WR;
                end else begin
                    s_next = cet_pkg::clip_exc(50'(signed'({1'b0, r_exc})) + 50'(val_reg));
                    cnt_next = r_cnt;
                    state_next = cet_pkg::ST_DIV;
                end
            end
            cet_pkg::ST_DIV: begin
                if (!pass2_reg) begin
                    dstart = (band_gap_reg != 16'd0);
                    pass2_next = 1'b1;
                end else if (!dbusy) begin
                    if (band_gap_reg != 16'd0)
                        cnt_next = cet_pkg::clip_cnt(34'(cnt_reg) + 34'(dquo));
                    state_next = cet_pkg::ST_SINGLE_WR;
                end
            end
            cet_pkg::ST_SINGLE_WR: begin
                wr_en = 1'b1;
                wr_addr = AW'(idx_reg);
                wr_data = {mark_reg, cnt_reg, s_reg};
                state_next = cet_pkg::ST_OUT;
            end
            cet_pkg::ST_SCAN1, cet_pkg::ST_SCAN2: begin
                // issue reads, process previous read data
                if (rp_reg < (AW+1)'(SYMBOLS)) begin
                    rd_addr = rp_reg[AW-1:0];
                    rp_next = rp_reg + 1'b1;
                    rv_next = 1'b1;
                end
                if (rv_reg) begin
                    wp_next = wp_reg + 1'b1;
                    if (state_reg == cet_pkg::ST_SCAN1 && need_max) begin
                        // max-finding pass
                        if (r_cnt > mxc_reg) mxc_next = r_cnt;
                        if (r_exc > mxe_reg) mxe_next = r_exc;
                        if (r_exc != 32'd0) any_next = 1'b1;
                    end else begin
                        case (func_reg)
                            cet_pkg::FN_ADD_ALL: begin
                                if (sel_all) begin
                                    wr_en = 1'b1;
                                    wr_data = {r_mark, cet_pkg::clip_cnt(cnt_sum),
                                               cet_pkg::clip_exc(sum_add)};
                                end
                            end
                            cet_pkg::FN_FREEZE: begin
                                wr_en = 1'b1;
                                wr_data = {(r_exc != 32'd0), r_cnt, r_exc};
                            end
                            cet_pkg::FN_ELEM: begin
                                // clear all rows; the winner is restored at the end
                                wr_en = 1'b1;
                                wr_data = '0;
                                if (qual && (!have_reg || r_exc > best_exc_reg)) begin
                                    have_next = 1'b1;
                                    best_next = wrow;
                                    best_exc_next = r_exc;
                                    cnt_next = r_cnt;
                                end
                            end
                            default: begin // partial
                                wr_en = 1'b1;
                                if (multi_reg ? (r_exc > thr_reg) : qual) begin
                                    kept_next = kept_reg + 11'd1;
                                    wr_data = {(r_exc != 32'd0), r_cnt, r_exc};
                                end else begin
                                    wr_data = '0;
                                end
                            end
                        endcase
                    end
                end
                if (!rv_reg && rp_reg == (AW+1)'(SYMBOLS)) begin
                    // pass done
                    if (state_reg == cet_pkg::ST_SCAN1 && need_max) begin
                        rp_next = '0; wp_next = '0;
                        kact_next = 18'(signed'({2'b0, mxc_reg})) + 18'sd1 + 18'(k_reg);
                        thr_next = (mxe_reg > 32'(band_gap_reg)) ?
                                   mxe_reg - 32'(band_gap_reg) : 32'd0;
                        if (multi_reg && !is_elem && !any_reg) begin
                            // nothing active: marks off, counts stay
                            state_next = cet_pkg::ST_SCAN2;
                            func_reg_fix = 1'b1;
                        end else begin
                            state_next = cet_pkg::ST_SCAN2;
                        end
                    end else begin
                        if (func_reg != cet_pkg::FN_ADD_ALL) frozen_next = 1'b1;
                        if (is_elem && have_reg) begin
                            wr_en = 1'b1;
                            wr_addr = best_reg;
                            wr_data = {1'b1, cnt_reg, best_exc_reg};
                            kept_next = 11'd1;
                        end
                        state_next = cet_pkg::ST_OUT;
                    end
                end
            end
            cet_pkg::ST_OUT: begin
                if (!mv_reg) begin
                    mv_next = 1'b1;
                    state_next = cet_pkg::ST_IDLE;
                end
            end
            default: state_next = cet_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cet_pkg::ST_CLEAR;
            frozen_reg <= 1'b0;
            mv_reg <= 1'b0;
            rp_reg <= '0;
            rv_reg <= 1'b0;
            func_reg <= cet_pkg::FN_ACTIVATE;
        end else begin
            state_reg <= state_next;
            frozen_reg <= frozen_next;
            mv_reg <= mv_next;
            rp_reg <= rp_next;
            rv_reg <= rv_next;
            if (s_valid && s_ready) func_reg <= s_func;
            else if (func_reg_fix) func_reg <= cet_pkg::FN_FREEZE;
        end
        if (s_valid && s_ready) begin
            idx_reg <= s_symbol_index;
            val_reg <= s_value;
            k_reg <= s_k;
            multi_reg <= s_multi_mode;
        end
        wp_reg <= wp_next; mxc_reg <= mxc_next; mxe_reg <= mxe_next;
        any_reg <= any_next; best_exc_reg <= best_exc_next; best_reg <= best_next;
        have_reg <= have_next; kept_reg <= kept_next; err_reg <= err_next;
        kact_reg <= kact_next; thr_reg <= thr_next; s_reg <= s_next;
        cnt_reg <= cnt_next; mark_reg <= mark_next; pass2_reg <= pass2_next;
    end
endmodule
